>>> src/wcpu_pkg.sv
// Shared types, constants and helpers of the word CPU step core.
package wcpu_pkg;

    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Instruction word fields
    localparam logic [15:0] OP_MASK = 16'h001f;
    localparam logic [15:0] B_MASK  = 16'h03e0;
    localparam logic [15:0] A_MASK  = 16'hfc00;
    localparam int          B_LSB   = 5;
    localparam int          A_LSB   = 10;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_READ = 2'd1,
        ACT_EXEC = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_ILLEGAL = 3'd1,
        STS_BREAK   = 3'd2,
        STS_HWQ     = 3'd3,
        STS_HWI     = 3'd4,
        STS_INT     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_RD, ST_FETCH, ST_OPD, ST_OPW, ST_OPR,
        ST_EXEC, ST_DIV, ST_WB, ST_RFI1, ST_RFI2, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        LK_REG, LK_MEM, LK_SP, LK_PC, LK_EX, LK_LIT
    } loc_kind_t;

    // Basic opcodes
    localparam logic [4:0] OP_SPECIAL = 5'h00;
    localparam logic [4:0] OP_SET = 5'h01;
    localparam logic [4:0] OP_ADD = 5'h02;
    localparam logic [4:0] OP_SUB = 5'h03;
    localparam logic [4:0] OP_MUL = 5'h04;
    localparam logic [4:0] OP_MLI = 5'h05;
    localparam logic [4:0] OP_DIV = 5'h06;
    localparam logic [4:0] OP_DVI = 5'h07;
    localparam logic [4:0] OP_MOD = 5'h08;
    localparam logic [4:0] OP_MDI = 5'h09;
    localparam logic [4:0] OP_AND = 5'h0a;
    localparam logic [4:0] OP_BOR = 5'h0b;
    localparam logic [4:0] OP_XOR = 5'h0c;
    localparam logic [4:0] OP_SHR = 5'h0d;
    localparam logic [4:0] OP_ASR = 5'h0e;
    localparam logic [4:0] OP_SHL = 5'h0f;
    localparam logic [4:0] OP_IFB = 5'h10;
    localparam logic [4:0] OP_IFC = 5'h11;
    localparam logic [4:0] OP_IFE = 5'h12;
    localparam logic [4:0] OP_IFN = 5'h13;
    localparam logic [4:0] OP_IFG = 5'h14;
    localparam logic [4:0] OP_IFA = 5'h15;
    localparam logic [4:0] OP_IFL = 5'h16;
    localparam logic [4:0] OP_IFU = 5'h17;
    localparam logic [4:0] OP_ADX = 5'h1a;
    localparam logic [4:0] OP_SBX = 5'h1b;
    localparam logic [4:0] OP_STI = 5'h1e;
    localparam logic [4:0] OP_STD = 5'h1f;

    // Special opcodes
    localparam logic [4:0] SP_BRK = 5'h00;
    localparam logic [4:0] SP_JSR = 5'h01;
    localparam logic [4:0] SP_TRC = 5'h02;
    localparam logic [4:0] SP_INT = 5'h08;
    localparam logic [4:0] SP_IAG = 5'h09;
    localparam logic [4:0] SP_IAS = 5'h0a;
    localparam logic [4:0] SP_RFI = 5'h0b;
    localparam logic [4:0] SP_IAQ = 5'h0c;
    localparam logic [4:0] SP_HWN = 5'h10;
    localparam logic [4:0] SP_HWQ = 5'h11;
    localparam logic [4:0] SP_HWI = 5'h12;

    // Operand codes
    localparam logic [5:0] OC_IND_REG  = 6'h08;
    localparam logic [5:0] OC_IDX_REG  = 6'h10;
    localparam logic [5:0] OC_PUSHPOP  = 6'h18;
    localparam logic [5:0] OC_PEEK     = 6'h19;
    localparam logic [5:0] OC_PICK     = 6'h1a;
    localparam logic [5:0] OC_SP       = 6'h1b;
    localparam logic [5:0] OC_PC       = 6'h1c;
    localparam logic [5:0] OC_EX       = 6'h1d;
    localparam logic [5:0] OC_NW_IND   = 6'h1e;
    localparam logic [5:0] OC_NW_LIT   = 6'h1f;
    localparam logic [5:0] OC_LIT_BASE = 6'h21;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } div_res_t;

    function automatic logic uses_word(input logic [5:0] c);
        return (c >= OC_IDX_REG && c < OC_PUSHPOP) || c == OC_PICK
            || c == OC_NW_IND || c == OC_NW_LIT;
    endfunction

    function automatic logic is_cond(input logic [4:0] op);
        return op >= OP_IFB && op <= OP_IFU;
    endfunction

endpackage

>>> src/wcpu_if.sv
// Request and result channel interfaces.
interface wcpu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] address;
    logic [15:0] data;
    modport source (output valid, action, address, data, input ready);
    modport sink   (input valid, action, address, data, output ready);
endinterface

interface wcpu_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] read_data;
    logic [15:0] program_counter;
    logic [2:0]  cycles_used;
    logic [15:0] device_index;
    modport source (output valid, status, read_data, program_counter, cycles_used,
                    device_index, input ready);
    modport sink   (input valid, status, read_data, program_counter, cycles_used,
                    device_index, output ready);
endinterface

>>> src/word_cpu_instruction_step_core.sv
// Word CPU step core: sequencer around one single-port main memory.
// Load writes one word, read returns one word; execute fetches the instruction,
// up to two next words, up to two operand reads, then writes back, and
// DIV/DVI/MOD/MDI also wait on the divider. One item in flight.
// After reset a clearing pass writes zero to all MEM_WORDS words, one a cycle;
// no request is taken until it ends. Registers, PC, SP, EX, IA clear at once.
module word_cpu_instruction_step_core (
    input  logic             clk,
    input  logic             rst_n,
    wcpu_req_if.sink         request,
    wcpu_rsp_if.source       result,
    input  logic             device_count_we,
    input  logic [15:0]      device_count_wdata
);
    localparam int AW = wcpu_pkg::MEM_AW;

    wcpu_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;

    // architectural state
    logic [15:0] gr_reg [8];
    logic [15:0] gr_next [8];
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] ex_reg, ex_next;
    logic [15:0] iaddr_reg, iaddr_next;
    logic        skip_reg, skip_next;
    logic        queue_reg, queue_next;
    logic [15:0] dcount_reg;

    // per-item working registers
    logic [2:0]  st_reg, st_next;
    logic [15:0] rd_reg, rd_next;
    logic [2:0]  cyc_reg, cyc_next;
    logic [15:0] dev_reg, dev_next;
    logic [4:0]  op_reg, op_next;
    logic [5:0]  ea_reg, ea_next;
    logic [4:0]  eb_reg, eb_next;
    logic        selb_reg, selb_next;
    wcpu_pkg::loc_kind_t a_kind_reg, a_kind_next, b_kind_reg, b_kind_next;
    wcpu_pkg::loc_kind_t wb_kind_reg, wb_kind_next, cur_kind_reg, cur_kind_next;
    logic [15:0] a_idx_reg, a_idx_next, b_idx_reg, b_idx_next, a_val_reg, a_val_next;
    logic [15:0] b_val_reg, b_val_next, cur_idx_reg, cur_idx_next;
    logic [15:0] wb_idx_reg, wb_idx_next, wb_val_reg, wb_val_next;
    logic        up_reg, up_next, dn_reg, dn_next;

    // result register
    logic        o_valid_reg, o_valid_next;
    logic [2:0]  o_st_reg, o_st_next;
    logic [15:0] o_rd_reg, o_rd_next, o_pc_reg, o_pc_next, o_dev_reg, o_dev_next;
    logic [2:0]  o_cyc_reg, o_cyc_next;

    // memory port
    logic        mem_we;
    logic [15:0] mem_addr, mem_wdata, mem_rdata;

    // divider
    logic        div_start;
    logic [31:0] div_dvd;
    logic [15:0] div_dvs;
    wcpu_pkg::div_res_t div_res;

    wcpu_ram #(.DEPTH(wcpu_pkg::MEM_WORDS), .WIDTH(16)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr[AW-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    wcpu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .res      (div_res)
    );

    assign request.ready          = (state_reg == wcpu_pkg::ST_IDLE);
    assign result.valid           = o_valid_reg;
    assign result.status          = o_st_reg;
    assign result.read_data       = o_rd_reg;
    assign result.program_counter = o_pc_reg;
    assign result.cycles_used     = o_cyc_reg;
    assign result.device_index    = o_dev_reg;

    always_comb
    begin
        logic [5:0]  code;
        logic [15:0] gr_rd;
        logic        fin;
        wcpu_pkg::loc_kind_t f_kind;
        logic [15:0] f_idx, f_val;
        logic [15:0] av, bv;
        logic [16:0] sum17, dif17;
        logic [17:0] adx18, sbx18;
        logic [31:0] mul32, mli32, shr32, asr32, shl32, q_neg;
        logic [4:0]  asr_sh;
        logic        cond, neg;
        logic [1:0]  nw;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        gr_next      = gr_reg;
        pc_next      = pc_reg;
        sp_next      = sp_reg;
        ex_next      = ex_reg;
        iaddr_next   = iaddr_reg;
        skip_next    = skip_reg;
        queue_next   = queue_reg;
        st_next      = st_reg;
        rd_next      = rd_reg;
        cyc_next     = cyc_reg;
        dev_next     = dev_reg;
        op_next      = op_reg;
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        selb_next    = selb_reg;
        a_kind_next  = a_kind_reg;
        a_idx_next   = a_idx_reg;
        a_val_next   = a_val_reg;
        b_kind_next  = b_kind_reg;
        b_idx_next   = b_idx_reg;
        b_val_next   = b_val_reg;
        cur_kind_next = cur_kind_reg;
        cur_idx_next  = cur_idx_reg;
        wb_kind_next = wb_kind_reg;
        wb_idx_next  = wb_idx_reg;
        wb_val_next  = wb_val_reg;
        up_next      = up_reg;
        dn_next      = dn_reg;
        o_valid_next = o_valid_reg && !result.ready;
        o_st_next    = o_st_reg;
        o_rd_next    = o_rd_reg;
        o_pc_next    = o_pc_reg;
        o_cyc_next   = o_cyc_reg;
        o_dev_next   = o_dev_reg;
        mem_we       = 1'b0;
        mem_addr     = pc_reg;
        mem_wdata    = '0;
        div_start    = 1'b0;
        div_dvd      = '0;
        div_dvs      = '0;

        code   = selb_reg ? {1'b0, eb_reg} : ea_reg;
        gr_rd  = gr_reg[code[2:0]];
        fin    = 1'b0;
        f_kind = wcpu_pkg::LK_MEM;
        f_idx  = '0;
        f_val  = '0;
        av     = a_val_reg;
        bv     = b_val_reg;
        sum17  = {1'b0, bv} + {1'b0, av};
        dif17  = {1'b0, bv} - {1'b0, av};
        adx18  = {2'b00, bv} + {2'b00, av} + {2'b00, ex_reg};
        sbx18  = {2'b00, bv} - {2'b00, av} + {2'b00, ex_reg};
        mul32  = bv * av;
        mli32  = 32'($signed(bv) * $signed(av));
        shr32  = (av >= 16'd32) ? 32'd0 : ({bv, 16'd0} >> av[4:0]);
        asr_sh = (av >= 16'd31) ? 5'd31 : av[4:0];
        asr32  = 32'($signed({bv, 16'd0}) >>> asr_sh);
        shl32  = (av >= 16'd32) ? 32'd0 : ({16'd0, bv} << av[4:0]);
        q_neg  = 32'd0 - div_res.quotient;
        cond   = 1'b0;
        neg    = 1'b0;
        nw     = '0;

        unique case (state_reg)
            wcpu_pkg::ST_CLR:
            begin
                mem_we       = 1'b1;
                mem_addr     = 16'(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = wcpu_pkg::ST_IDLE;
                end
            end
            wcpu_pkg::ST_IDLE:
            begin
                if (request.valid)
                begin
                    st_next  = wcpu_pkg::STS_OK;
                    rd_next  = '0;
                    cyc_next = '0;
                    dev_next = '0;
                    unique case (wcpu_pkg::action_t'(request.action))
                        wcpu_pkg::ACT_LOAD:
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = request.address;
                            mem_wdata  = request.data;
                            state_next = wcpu_pkg::ST_DONE;
                        end
                        wcpu_pkg::ACT_READ:
                        begin
                            mem_addr   = request.address;
                            state_next = wcpu_pkg::ST_RD;
                        end
                        wcpu_pkg::ACT_EXEC:
                        begin
                            mem_addr   = pc_reg;
                            pc_next    = pc_reg + 16'd1;
                            cyc_next   = 3'd1;
                            state_next = wcpu_pkg::ST_FETCH;
                        end
                        wcpu_pkg::ACT_NONE:
                        begin
                            state_next = wcpu_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = wcpu_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            wcpu_pkg::ST_RD:
            begin
                rd_next    = mem_rdata;
                state_next = wcpu_pkg::ST_DONE;
            end
            wcpu_pkg::ST_FETCH:
            begin
                op_next   = 5'(mem_rdata & wcpu_pkg::OP_MASK);
                eb_next   = 5'((mem_rdata & wcpu_pkg::B_MASK) >> wcpu_pkg::B_LSB);
                ea_next   = 6'((mem_rdata & wcpu_pkg::A_MASK) >> wcpu_pkg::A_LSB);
                selb_next = 1'b0;
                if (skip_reg)
                begin
                    // skipped word: pass over its next words only
                    nw = {1'b0, wcpu_pkg::uses_word(ea_next)}
                       + ((op_next == wcpu_pkg::OP_SPECIAL) ? 2'd0
                          : {1'b0, wcpu_pkg::uses_word({1'b0, eb_next})});
                    pc_next  = pc_reg + 16'(nw);
                    cyc_next = cyc_reg + 3'(nw);
                    if (!wcpu_pkg::is_cond(op_next))
                    begin
                        skip_next = 1'b0;
                    end
                    state_next = wcpu_pkg::ST_DONE;
                end
                else
                begin
                    state_next = wcpu_pkg::ST_OPD;
                end
            end
            wcpu_pkg::ST_OPD:
            begin
                priority if (code < wcpu_pkg::OC_IND_REG)
                begin
                    fin = 1'b1; f_kind = wcpu_pkg::LK_REG;
                    f_idx = 16'(code); f_val = gr_rd;
                end
                else if (code < wcpu_pkg::OC_IDX_REG)
                begin
                    cur_kind_next = wcpu_pkg::LK_MEM;
                    cur_idx_next  = gr_rd;
                    mem_addr      = gr_rd;
                    state_next    = wcpu_pkg::ST_OPR;
                end
                else if (wcpu_pkg::uses_word(code))
                begin
                    mem_addr   = pc_reg;
                    pc_next    = pc_reg + 16'd1;
                    cyc_next   = cyc_reg + 3'd1;
                    state_next = wcpu_pkg::ST_OPW;
                end
                else if (code == wcpu_pkg::OC_PUSHPOP)
                begin
                    cur_kind_next = wcpu_pkg::LK_MEM;
                    if (!selb_reg)
                    begin
                        cur_idx_next = sp_reg;
                        mem_addr     = sp_reg;
                        sp_next      = sp_reg + 16'd1;
                    end
                    else
                    begin
                        cur_idx_next = sp_reg - 16'd1;
                        mem_addr     = sp_reg - 16'd1;
                        sp_next      = sp_reg - 16'd1;
                    end
                    state_next = wcpu_pkg::ST_OPR;
                end
                else if (code == wcpu_pkg::OC_PEEK)
                begin
                    cur_kind_next = wcpu_pkg::LK_MEM;
                    cur_idx_next  = sp_reg;
                    mem_addr      = sp_reg;
                    state_next    = wcpu_pkg::ST_OPR;
                end
                else if (code == wcpu_pkg::OC_SP)
                begin
                    fin = 1'b1; f_kind = wcpu_pkg::LK_SP; f_val = sp_reg;
                end
                else if (code == wcpu_pkg::OC_PC)
                begin
                    fin = 1'b1; f_kind = wcpu_pkg::LK_PC; f_val = pc_reg;
                end
                else if (code == wcpu_pkg::OC_EX)
                begin
                    fin = 1'b1; f_kind = wcpu_pkg::LK_EX; f_val = ex_reg;
                end
                else
                begin
                    // short literal: code minus 0x21, wrapping to 0xffff
                    fin = 1'b1; f_kind = wcpu_pkg::LK_LIT;
                    f_val = 16'(code) - 16'(wcpu_pkg::OC_LIT_BASE);
                    f_idx = f_val;
                end
            end
            wcpu_pkg::ST_OPW:
            begin
                cur_kind_next = wcpu_pkg::LK_MEM;
                priority if (code == wcpu_pkg::OC_NW_LIT)
                begin
                    fin = 1'b1; f_kind = wcpu_pkg::LK_LIT;
                    f_idx = mem_rdata; f_val = mem_rdata;
                end
                else if (code == wcpu_pkg::OC_NW_IND)
                begin
                    cur_idx_next = mem_rdata;
                    mem_addr     = mem_rdata;
                    state_next   = wcpu_pkg::ST_OPR;
                end
                else if (code == wcpu_pkg::OC_PICK)
                begin
                    cur_idx_next = sp_reg + mem_rdata;
                    mem_addr     = sp_reg + mem_rdata;
                    state_next   = wcpu_pkg::ST_OPR;
                end
                else
                begin
                    cur_idx_next = gr_rd + mem_rdata;
                    mem_addr     = gr_rd + mem_rdata;
                    state_next   = wcpu_pkg::ST_OPR;
                end
            end
            wcpu_pkg::ST_OPR:
            begin
                fin = 1'b1; f_kind = cur_kind_reg; f_idx = cur_idx_reg; f_val = mem_rdata;
            end
            wcpu_pkg::ST_EXEC:
            begin
                state_next = wcpu_pkg::ST_DONE;
                if (op_reg == wcpu_pkg::OP_SPECIAL)
                begin
                    unique case (eb_reg)
                        wcpu_pkg::SP_BRK: st_next = wcpu_pkg::STS_BREAK;
                        wcpu_pkg::SP_JSR:
                        begin
                            sp_next      = sp_reg - 16'd1;
                            pc_next      = av;
                            cyc_next     = cyc_reg + 3'd2;
                            wb_kind_next = wcpu_pkg::LK_MEM;
                            wb_idx_next  = sp_reg - 16'd1;
                            wb_val_next  = pc_reg;
                            state_next   = wcpu_pkg::ST_WB;
                        end
                        wcpu_pkg::SP_TRC: st_next = wcpu_pkg::STS_OK;
                        wcpu_pkg::SP_INT:
                        begin
                            cyc_next = cyc_reg + 3'd3;
                            dev_next = av;
                            st_next  = wcpu_pkg::STS_INT;
                        end
                        wcpu_pkg::SP_IAG:
                        begin
                            wb_kind_next = a_kind_reg;
                            wb_idx_next  = a_idx_reg;
                            wb_val_next  = iaddr_reg;
                            state_next   = wcpu_pkg::ST_WB;
                        end
                        wcpu_pkg::SP_IAS: iaddr_next = av;
                        wcpu_pkg::SP_RFI:
                        begin
                            queue_next = 1'b0;
                            cyc_next   = cyc_reg + 3'd2;
                            mem_addr   = sp_reg;
                            state_next = wcpu_pkg::ST_RFI1;
                        end
                        wcpu_pkg::SP_IAQ:
                        begin
                            queue_next = (av != 16'd0);
                            cyc_next   = cyc_reg + 3'd1;
                        end
                        wcpu_pkg::SP_HWN:
                        begin
                            cyc_next     = cyc_reg + 3'd1;
                            wb_kind_next = a_kind_reg;
                            wb_idx_next  = a_idx_reg;
                            wb_val_next  = dcount_reg;
                            state_next   = wcpu_pkg::ST_WB;
                        end
                        wcpu_pkg::SP_HWQ:
                        begin
                            cyc_next = cyc_reg + 3'd3;
                            dev_next = av;
                            st_next  = wcpu_pkg::STS_HWQ;
                        end
                        wcpu_pkg::SP_HWI:
                        begin
                            cyc_next = cyc_reg + 3'd3;
                            dev_next = av;
                            st_next  = wcpu_pkg::STS_HWI;
                        end
                        default: st_next = wcpu_pkg::STS_ILLEGAL;
                    endcase
                end
                else if (wcpu_pkg::is_cond(op_reg))
                begin
                    unique case (op_reg)
                        wcpu_pkg::OP_IFB: cond = (bv & av) != 16'd0;
                        wcpu_pkg::OP_IFC: cond = (bv & av) == 16'd0;
                        wcpu_pkg::OP_IFE: cond = bv == av;
                        wcpu_pkg::OP_IFN: cond = bv != av;
                        wcpu_pkg::OP_IFG: cond = bv > av;
                        wcpu_pkg::OP_IFA: cond = $signed(bv) > $signed(av);
                        wcpu_pkg::OP_IFL: cond = bv < av;
                        default:          cond = $signed(bv) < $signed(av);
                    endcase
                    cyc_next = cyc_reg + (cond ? 3'd1 : 3'd2);
                    if (!cond)
                    begin
                        skip_next = 1'b1;
                    end
                end
                else
                begin
                    wb_kind_next = b_kind_reg;
                    wb_idx_next  = b_idx_reg;
                    state_next   = wcpu_pkg::ST_WB;
                    unique case (op_reg)
                        wcpu_pkg::OP_SET: wb_val_next = av;
                        wcpu_pkg::OP_ADD:
                        begin
                            wb_val_next = sum17[15:0];
                            ex_next     = {15'd0, sum17[16]};
                            cyc_next    = cyc_reg + 3'd1;
                        end
                        wcpu_pkg::OP_SUB:
                        begin
                            wb_val_next = dif17[15:0];
                            ex_next     = {16{dif17[16]}};
                            cyc_next    = cyc_reg + 3'd1;
                        end
                        wcpu_pkg::OP_MUL:
                        begin
                            wb_val_next = mul32[15:0];
                            ex_next     = mul32[31:16];
                            cyc_next    = cyc_reg + 3'd1;
                        end
                        wcpu_pkg::OP_MLI:
                        begin
                            wb_val_next = mli32[15:0];
                            ex_next     = mli32[31:16];
                            cyc_next    = cyc_reg + 3'd1;
                        end
                        wcpu_pkg::OP_DIV, wcpu_pkg::OP_DVI,
                        wcpu_pkg::OP_MOD, wcpu_pkg::OP_MDI:
                        begin
                            div_start  = 1'b1;
                            cyc_next   = cyc_reg + 3'd2;
                            div_dvs    = (op_reg == wcpu_pkg::OP_DVI
                                          || op_reg == wcpu_pkg::OP_MDI)
                                         ? (av[15] ? 16'd0 - av : av) : av;
                            priority case (op_reg)
                                wcpu_pkg::OP_DIV: div_dvd = {bv, 16'd0};
                                wcpu_pkg::OP_DVI:
                                    div_dvd = {(bv[15] ? 16'd0 - bv : bv), 16'd0};
                                wcpu_pkg::OP_MOD: div_dvd = {16'd0, bv};
                                default:
                                    div_dvd = {16'd0, (bv[15] ? 16'd0 - bv : bv)};
                            endcase
                            state_next = wcpu_pkg::ST_DIV;
                        end
                        wcpu_pkg::OP_AND: wb_val_next = bv & av;
                        wcpu_pkg::OP_BOR: wb_val_next = bv | av;
                        wcpu_pkg::OP_XOR: wb_val_next = bv ^ av;
                        wcpu_pkg::OP_SHR:
                        begin
                            wb_val_next = shr32[31:16];
                            ex_next     = shr32[15:0];
                        end
                        wcpu_pkg::OP_ASR:
                        begin
                            wb_val_next = asr32[31:16];
                            ex_next     = asr32[15:0];
                        end
                        wcpu_pkg::OP_SHL:
                        begin
                            wb_val_next = shl32[15:0];
                            ex_next     = shl32[31:16];
                        end
                        wcpu_pkg::OP_ADX:
                        begin
                            wb_val_next = adx18[15:0];
                            ex_next     = (adx18[17:16] != 2'd0) ? 16'd1 : 16'd0;
                            cyc_next    = cyc_reg + 3'd2;
                        end
                        wcpu_pkg::OP_SBX:
                        begin
                            wb_val_next = sbx18[15:0];
                            ex_next     = sbx18[17] ? 16'hffff
                                        : (sbx18[16] ? 16'd1 : 16'd0);
                            cyc_next    = cyc_reg + 3'd2;
                        end
                        wcpu_pkg::OP_STI, wcpu_pkg::OP_STD:
                        begin
                            wb_val_next = av;
                            up_next     = (op_reg == wcpu_pkg::OP_STI);
                            dn_next     = (op_reg == wcpu_pkg::OP_STD);
                            cyc_next    = cyc_reg + 3'd1;
                        end
                        default:
                        begin
                            st_next    = wcpu_pkg::STS_ILLEGAL;
                            state_next = wcpu_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            wcpu_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = wcpu_pkg::ST_WB;
                    priority case (op_reg)
                        wcpu_pkg::OP_DIV:
                        begin
                            wb_val_next = div_res.quotient[31:16];
                            ex_next     = div_res.quotient[15:0];
                        end
                        wcpu_pkg::OP_DVI:
                        begin
                            neg = av[15] ^ bv[15];
                            wb_val_next = neg ? 16'd0 - div_res.quotient[31:16]
                                              : div_res.quotient[31:16];
                            ex_next     = neg ? q_neg[15:0] : div_res.quotient[15:0];
                        end
                        wcpu_pkg::OP_MOD: wb_val_next = div_res.remainder;
                        default:
                        begin
                            neg = bv[15];
                            wb_val_next = neg ? 16'd0 - div_res.remainder
                                              : div_res.remainder;
                        end
                    endcase
                    // division by zero gives zero, and zero EX for DIV and DVI
                    if (av == 16'd0)
                    begin
                        wb_val_next = '0;
                        if (op_reg == wcpu_pkg::OP_DIV || op_reg == wcpu_pkg::OP_DVI)
                        begin
                            ex_next = '0;
                        end
                    end
                end
            end
            wcpu_pkg::ST_WB:
            begin
                unique case (wb_kind_reg)
                    wcpu_pkg::LK_REG: gr_next[wb_idx_reg[2:0]] = wb_val_reg;
                    wcpu_pkg::LK_MEM:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = wb_idx_reg;
                        mem_wdata = wb_val_reg;
                    end
                    wcpu_pkg::LK_SP:  sp_next = wb_val_reg;
                    wcpu_pkg::LK_PC:  pc_next = wb_val_reg;
                    wcpu_pkg::LK_EX:  ex_next = wb_val_reg;
                    default: ;
                endcase
                if (up_reg)
                begin
                    gr_next[6] = gr_next[6] + 16'd1;
                    gr_next[7] = gr_next[7] + 16'd1;
                end
                else if (dn_reg)
                begin
                    gr_next[6] = gr_next[6] - 16'd1;
                    gr_next[7] = gr_next[7] - 16'd1;
                end
                state_next = wcpu_pkg::ST_DONE;
            end
            wcpu_pkg::ST_RFI1:
            begin
                gr_next[0] = mem_rdata;
                sp_next    = sp_reg + 16'd1;
                mem_addr   = sp_reg + 16'd1;
                state_next = wcpu_pkg::ST_RFI2;
            end
            wcpu_pkg::ST_RFI2:
            begin
                pc_next    = mem_rdata;
                sp_next    = sp_reg + 16'd1;
                state_next = wcpu_pkg::ST_DONE;
            end
            wcpu_pkg::ST_DONE:
            begin
                if (!o_valid_reg || result.ready)
                begin
                    o_valid_next = 1'b1;
                    o_st_next    = st_reg;
                    o_rd_next    = rd_reg;
                    o_pc_next    = pc_reg;
                    o_cyc_next   = cyc_reg;
                    o_dev_next   = dev_reg;
                    state_next   = wcpu_pkg::ST_IDLE;
                end
            end
            default: state_next = wcpu_pkg::ST_IDLE;
        endcase

        // operand located: keep it and move on to the b operand or execution
        if (fin)
        begin
            if (!selb_reg)
            begin
                a_kind_next = f_kind; a_idx_next = f_idx; a_val_next = f_val;
                if (op_reg == wcpu_pkg::OP_SPECIAL)
                begin
                    state_next = wcpu_pkg::ST_EXEC;
                end
                else
                begin
                    selb_next  = 1'b1;
                    state_next = wcpu_pkg::ST_OPD;
                end
            end
            else
            begin
                b_kind_next = f_kind; b_idx_next = f_idx; b_val_next = f_val;
                state_next  = wcpu_pkg::ST_EXEC;
            end
        end
        if (state_reg == wcpu_pkg::ST_FETCH)
        begin
            up_next = 1'b0;
            dn_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wcpu_pkg::ST_CLR;
            clr_cnt_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                gr_reg[i] <= '0;
            end
            pc_reg      <= '0;
            sp_reg      <= '0;
            ex_reg      <= '0;
            iaddr_reg   <= '0;
            skip_reg    <= 1'b0;
            queue_reg   <= 1'b0;
            dcount_reg  <= '0;
            o_valid_reg <= 1'b0;
            up_reg      <= 1'b0;
            dn_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            gr_reg      <= gr_next;
            pc_reg      <= pc_next;
            sp_reg      <= sp_next;
            ex_reg      <= ex_next;
            iaddr_reg   <= iaddr_next;
            skip_reg    <= skip_next;
            queue_reg   <= queue_next;
            if (device_count_we)
            begin
                dcount_reg <= device_count_wdata;
            end
            o_valid_reg <= o_valid_next;
            up_reg      <= up_next;
            dn_reg      <= dn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg       <= st_next;
        rd_reg       <= rd_next;
        cyc_reg      <= cyc_next;
        dev_reg      <= dev_next;
        op_reg       <= op_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        selb_reg     <= selb_next;
        a_kind_reg   <= a_kind_next;
        a_idx_reg    <= a_idx_next;
        a_val_reg    <= a_val_next;
        b_kind_reg   <= b_kind_next;
        b_idx_reg    <= b_idx_next;
        b_val_reg    <= b_val_next;
        cur_kind_reg <= cur_kind_next;
        cur_idx_reg  <= cur_idx_next;
        wb_kind_reg  <= wb_kind_next;
        wb_idx_reg   <= wb_idx_next;
        wb_val_reg   <= wb_val_next;
        o_st_reg     <= o_st_next;
        o_rd_reg     <= o_rd_next;
        o_pc_reg     <= o_pc_next;
        o_cyc_reg    <= o_cyc_next;
        o_dev_reg    <= o_dev_next;
    end

`ifndef ASSERT_OFF
    a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wcpu_pkg::ST_CLR) |-> !request.ready)
        else $error("request taken during clearing pass");
    a_wb_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wcpu_pkg::ST_WB) |->
        ($past(state_reg) == wcpu_pkg::ST_EXEC || $past(state_reg) == wcpu_pkg::ST_DIV))
        else $error("write-back without execute");
    a_rfi_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wcpu_pkg::ST_RFI2) |-> !queue_reg)
        else $error("queueing left on by RFI");
    a_cyc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wcpu_pkg::ST_DONE) |-> (cyc_reg <= 3'd5))
        else $error("cycle charge out of range");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == wcpu_pkg::ST_DIV))
        else $error("divider finished outside divide wait");
`endif
endmodule

>>> src/wcpu_ram.sv
// Single-port synchronous RAM with registered read data.
module wcpu_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> src/wcpu_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
module wcpu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [15:0]       divisor,
    output wcpu_pkg::div_res_t res
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;
endmodule

>>> sim/word_cpu_step_checker.sv
// Transfer monitor, instruction-level predictor and result scoreboard for the word CPU step core.
module word_cpu_step_checker
    import wcpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  req_action,
    input  logic [15:0] req_address,
    input  logic [15:0] req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [2:0]  rsp_status,
    input  logic [15:0] rsp_read_data,
    input  logic [15:0] rsp_program_counter,
    input  logic [2:0]  rsp_cycles_used,
    input  logic [15:0] rsp_device_index,
    input  logic        device_count_we,
    input  logic [15:0] device_count_wdata,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        status_t     status;
        logic [15:0] read_data;
        logic [15:0] pc;
        logic [2:0]  cycles;
        logic [15:0] device;
    } step_out_t;

    typedef struct packed {
        loc_kind_t   kind;
        logic [15:0] idx;
    } operand_t;

    step_out_t   expected_q[$];

    logic [15:0] memory_words [MEM_WORDS];
    logic [15:0] gpr [8];
    logic [15:0] pc_now;
    logic [15:0] sp_now;
    logic [15:0] ex_now;
    logic [15:0] ia_now;
    logic        skipping;
    logic        queueing;
    logic [15:0] hw_count;
    int          cycle_tally;
    logic [15:0] device_arg;

    assign outstanding = expected_q.size();

    function automatic logic takes_word(input logic [5:0] code);
        return (code >= OC_IDX_REG && code < OC_PUSHPOP) || code == OC_PICK
            || code == OC_NW_IND || code == OC_NW_LIT;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [15:0] w;
        w = memory_words[pc_now];
        pc_now = pc_now + 16'd1;
        cycle_tally++;
        return w;
    endfunction

    // a-operands pop, b-operands push
    function automatic operand_t locate(input logic [5:0] code, input logic is_a);
        operand_t l;
        l.kind = LK_MEM;
        l.idx  = '0;
        if (code < OC_IND_REG)
        begin
            l.kind = LK_REG;
            l.idx  = 16'(code[2:0]);
        end
        else if (code < OC_IDX_REG)
            l.idx = gpr[code[2:0]];
        else if (code < OC_PUSHPOP)
            l.idx = gpr[code[2:0]] + fetch_word();
        else if (code == OC_PUSHPOP)
        begin
            if (is_a)
            begin
                l.idx  = sp_now;
                sp_now = sp_now + 16'd1;
            end
            else
            begin
                sp_now = sp_now - 16'd1;
                l.idx  = sp_now;
            end
        end
        else if (code == OC_PEEK)
            l.idx = sp_now;
        else if (code == OC_PICK)
            l.idx = sp_now + fetch_word();
        else if (code == OC_SP)
            l.kind = LK_SP;
        else if (code == OC_PC)
            l.kind = LK_PC;
        else if (code == OC_EX)
            l.kind = LK_EX;
        else if (code == OC_NW_IND)
            l.idx = fetch_word();
        else if (code == OC_NW_LIT)
        begin
            l.kind = LK_LIT;
            l.idx  = fetch_word();
        end
        else
        begin
            l.kind = LK_LIT;
            l.idx  = 16'(code) - 16'h0021;
        end
        return l;
    endfunction

    function automatic logic [15:0] peek_operand(input operand_t l);
        case (l.kind)
            LK_REG:  return gpr[l.idx[2:0]];
            LK_MEM:  return memory_words[l.idx];
            LK_SP:   return sp_now;
            LK_PC:   return pc_now;
            LK_EX:   return ex_now;
            default: return l.idx;
        endcase
    endfunction

    // literal destinations swallow the write
    function automatic void poke_operand(input operand_t l, input logic [15:0] v);
        case (l.kind)
            LK_REG:  gpr[l.idx[2:0]] = v;
            LK_MEM:  memory_words[l.idx] = v;
            LK_SP:   sp_now = v;
            LK_PC:   pc_now = v;
            LK_EX:   ex_now = v;
            default: ;
        endcase
    endfunction

    function automatic status_t run_special(input logic [4:0] op, input logic [5:0] ea);
        operand_t    l;
        logic [15:0] v;
        l = locate(ea, 1'b1);
        v = peek_operand(l);
        case (op)
            SP_BRK: return STS_BREAK;
            SP_JSR:
            begin
                sp_now = sp_now - 16'd1;
                memory_words[sp_now] = pc_now;
                pc_now = v;
                cycle_tally += 2;
            end
            SP_TRC: ;
            SP_INT:
            begin
                cycle_tally += 3;
                device_arg = v;
                return STS_INT;
            end
            SP_IAG: poke_operand(l, ia_now);
            SP_IAS: ia_now = v;
            SP_RFI:
            begin
                queueing = 1'b0;
                gpr[0] = memory_words[sp_now];
                sp_now = sp_now + 16'd1;
                pc_now = memory_words[sp_now];
                sp_now = sp_now + 16'd1;
                cycle_tally += 2;
            end
            SP_IAQ:
            begin
                queueing = (v != 16'd0);
                cycle_tally++;
            end
            SP_HWN:
            begin
                poke_operand(l, hw_count);
                cycle_tally++;
            end
            SP_HWQ:
            begin
                cycle_tally += 3;
                device_arg = v;
                return STS_HWQ;
            end
            SP_HWI:
            begin
                cycle_tally += 3;
                device_arg = v;
                return STS_HWI;
            end
            default: return STS_ILLEGAL;
        endcase
        return STS_OK;
    endfunction

    function automatic status_t run_basic(input logic [4:0] op, input logic [5:0] ea,
                                          input logic [4:0] eb);
        operand_t    la;
        operand_t    lb;
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] r;
        logic [31:0] exv;
        int          sa;
        int          sb;
        int          t;
        int          s;
        longint      q;
        logic        cond;
        logic [63:0] x;
        logic [63:0] u;
        la   = locate(ea, 1'b1);
        a    = peek_operand(la);
        lb   = locate({1'b0, eb}, 1'b0);
        b    = peek_operand(lb);
        sa   = $signed(a);
        sb   = $signed(b);
        r    = '0;
        exv  = 32'(ex_now);
        cond = 1'b0;
        if (op >= OP_IFB && op <= OP_IFU)
        begin
            case (op)
                OP_IFB:  cond = (b & a) != 16'd0;
                OP_IFC:  cond = (b & a) == 16'd0;
                OP_IFE:  cond = b == a;
                OP_IFN:  cond = b != a;
                OP_IFG:  cond = b > a;
                OP_IFA:  cond = sb > sa;
                OP_IFL:  cond = b < a;
                default: cond = sb < sa;
            endcase
            cycle_tally++;
            if (!cond)
            begin
                cycle_tally++;
                skipping = 1'b1;
            end
            return STS_OK;
        end
        case (op)
            OP_SET: r = 32'(a);
            OP_ADD:
            begin
                r = 32'(b) + 32'(a);
                exv = r >> 16;
                cycle_tally++;
            end
            OP_SUB:
            begin
                r = 32'(b) - 32'(a);
                exv = (r >> 16) & 32'hffff;
                cycle_tally++;
            end
            OP_MUL:
            begin
                r = 32'(b) * 32'(a);
                exv = r >> 16;
                cycle_tally++;
            end
            OP_MLI:
            begin
                r = 32'(sb * sa);
                exv = r >> 16;
                cycle_tally++;
            end
            OP_DIV:
            begin
                if (a == 16'd0)
                begin
                    r = '0;
                    exv = '0;
                end
                else
                begin
                    r = 32'(b) / 32'(a);
                    exv = ((32'(b) << 16) / 32'(a)) & 32'hffff;
                end
                cycle_tally += 2;
            end
            OP_DVI:
            begin
                if (a == 16'd0)
                begin
                    r = '0;
                    exv = '0;
                end
                else
                begin
                    r = 32'(sb / sa) & 32'hffff;
                    q = (longint'(sb) * 65536) / sa;
                    exv = 32'(q[15:0]);
                end
                cycle_tally += 2;
            end
            OP_MOD:
            begin
                r = (a == 16'd0) ? 32'd0 : 32'(b % a);
                cycle_tally += 2;
            end
            OP_MDI:
            begin
                r = (a == 16'd0) ? 32'd0 : (32'(sb % sa) & 32'hffff);
                cycle_tally += 2;
            end
            OP_AND: r = 32'(b & a);
            OP_BOR: r = 32'(b | a);
            OP_XOR: r = 32'(b ^ a);
            OP_SHR:
            begin
                x = 64'(b) << 16;
                x = (a >= 16'd48) ? 64'd0 : (x >> a);
                r = 32'(x[31:16]);
                exv = 32'(x[15:0]);
            end
            OP_ASR:
            begin
                u = 64'(longint'(sb) * 65536);
                s = (a > 16'd63) ? 63 : int'(a);
                x = (sb < 0) ? ~((~u) >> s) : (u >> s);
                r = 32'(x[31:16]);
                exv = 32'(x[15:0]);
            end
            OP_SHL:
            begin
                x = (a >= 16'd32) ? 64'd0 : (64'(b) << a);
                r = 32'(x[15:0]);
                exv = 32'(x[31:16]);
            end
            OP_ADX:
            begin
                r = 32'(b) + 32'(a) + 32'(ex_now);
                exv = (r > 32'hffff) ? 32'd1 : 32'd0;
                cycle_tally += 2;
            end
            OP_SBX:
            begin
                t = int'(b) - int'(a) + int'(ex_now);
                r = 32'(t) & 32'hffff;
                exv = (t < 0) ? 32'hffff : ((t > 32'hffff) ? 32'd1 : 32'd0);
                cycle_tally += 2;
            end
            OP_STI, OP_STD:
            begin
                poke_operand(lb, a);
                gpr[6] = (op == OP_STI) ? gpr[6] + 16'd1 : gpr[6] - 16'd1;
                gpr[7] = (op == OP_STI) ? gpr[7] + 16'd1 : gpr[7] - 16'd1;
                cycle_tally++;
                return STS_OK;
            end
            default: return STS_ILLEGAL;
        endcase
        ex_now = exv[15:0];
        poke_operand(lb, r[15:0]);
        return STS_OK;
    endfunction

    function automatic step_out_t predict_step(input action_t act, input logic [15:0] addr,
                                               input logic [15:0] wdata);
        step_out_t   o;
        logic [15:0] ins;
        logic [4:0]  op;
        logic [4:0]  eb;
        logic [5:0]  ea;
        int          n;
        o = '0;
        o.status = STS_OK;
        if (act == ACT_LOAD)
            memory_words[addr] = wdata;
        else if (act == ACT_READ)
            o.read_data = memory_words[addr];
        else if (act == ACT_EXEC)
        begin
            cycle_tally = 0;
            device_arg  = '0;
            ins = fetch_word();
            op  = ins[4:0];
            eb  = ins[9:5];
            ea  = ins[15:10];
            if (skipping)
            begin
                // skipped word: only its next words are passed over
                n = int'(takes_word(ea)) + ((op == OP_SPECIAL) ? 0 : int'(takes_word({1'b0, eb})));
                pc_now = pc_now + 16'(n);
                cycle_tally += n;
                if (!(op >= OP_IFB && op <= OP_IFU))
                    skipping = 1'b0;
            end
            else if (op == OP_SPECIAL)
                o.status = run_special(eb, ea);
            else
                o.status = run_basic(op, ea, eb);
            o.cycles = (cycle_tally > 7) ? 3'd7 : 3'(cycle_tally);
            if (o.status >= STS_HWQ)
                o.device = device_arg;
        end
        o.pc = pc_now;
        return o;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_out_t want;
        if (!rst_n)
        begin
            foreach (memory_words[i])
                memory_words[i] = '0;
            foreach (gpr[i])
                gpr[i] = '0;
            pc_now     = '0;
            sp_now     = '0;
            ex_now     = '0;
            ia_now     = '0;
            skipping   = 1'b0;
            queueing   = 1'b0;
            hw_count   = '0;
            mismatches = 0;
            expected_q.delete();
        end
        else
        begin
            if (device_count_we)
                hw_count = device_count_wdata;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, got status %0d pc %h",
                             $time, rsp_status, rsp_program_counter);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("status", 16'(want.status), 16'(rsp_status));
                    compare_field("read_data", want.read_data, rsp_read_data);
                    compare_field("program_counter", want.pc, rsp_program_counter);
                    compare_field("cycles_used", 16'(want.cycles), 16'(rsp_cycles_used));
                    compare_field("device_index", want.device, rsp_device_index);
                end
            end
            if (req_valid && req_ready)
                expected_q.push_back(predict_step(action_t'(req_action), req_address, req_data));
        end
    end

endmodule

>>> sim/word_cpu_instruction_step_core_tb.sv
// Top of the word CPU step core testbench: clock, reset, stimulus and verdict.
module word_cpu_instruction_step_core_tb;
    import wcpu_pkg::*;

    localparam int PHASE_ITEMS = 425;
    // clearing pass plus ~1700 items at their slowest, several times over
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        device_count_we;
    logic [15:0] device_count_wdata;
    int          mismatches;
    int          outstanding;

    int          send_idle_pct;
    int          stall_pct;
    int          items_sent;
    int          results_seen;
    int          cycle_count;
    logic [15:0] last_pc;

    // special opcodes that the random programs draw from
    logic [4:0]  special_ops [11] = '{SP_BRK, SP_JSR, SP_TRC, SP_INT, SP_IAG, SP_IAS,
                                      SP_RFI, SP_IAQ, SP_HWN, SP_HWQ, SP_HWI};

    wcpu_req_if request_ch ();
    wcpu_rsp_if result_ch ();

    word_cpu_instruction_step_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .request            (request_ch.sink),
        .result             (result_ch.source),
        .device_count_we    (device_count_we),
        .device_count_wdata (device_count_wdata)
    );

    word_cpu_step_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (request_ch.valid),
        .req_ready           (request_ch.ready),
        .req_action          (request_ch.action),
        .req_address         (request_ch.address),
        .req_data            (request_ch.data),
        .rsp_valid           (result_ch.valid),
        .rsp_ready           (result_ch.ready),
        .rsp_status          (result_ch.status),
        .rsp_read_data       (result_ch.read_data),
        .rsp_program_counter (result_ch.program_counter),
        .rsp_cycles_used     (result_ch.cycles_used),
        .rsp_device_index    (result_ch.device_index),
        .device_count_we     (device_count_we),
        .device_count_wdata  (device_count_wdata),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, and the PC of the last transfer so that
    // programs can be placed where the core will fetch next.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (result_ch.valid && result_ch.ready)
        begin
            results_seen <= results_seen + 1;
            last_pc      <= result_ch.program_counter;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] encode(input logic [4:0] op, input logic [4:0] b,
                                           input logic [5:0] a);
        return {a, b, op};
    endfunction

    // Mostly legal instructions with random operands; a fifth are special opcodes,
    // a few of those unassigned ones.
    function automatic logic [15:0] random_insn();
        logic [4:0] op;
        logic [4:0] b;
        logic [5:0] a;
        op = 5'($urandom_range(31));
        b  = 5'($urandom_range(31));
        a  = 6'($urandom_range(63));
        if ($urandom_range(4) == 0)
        begin
            op = OP_SPECIAL;
            if ($urandom_range(7) != 0)
                b = special_ops[$urandom_range(10)];
        end
        return encode(op, b, a);
    endfunction

    // One transfer on the request channel; valid stays up between back-to-back items.
    task automatic send_item(input action_t act, input logic [15:0] addr, input logic [15:0] wd);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid   <= 1'b1;
        request_ch.action  <= act;
        request_ch.address <= addr;
        request_ch.data    <= wd;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold off until every expected result has come back.
    task automatic drain();
        request_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (items_sent != results_seen);
    endtask

    task automatic write_device_count(input logic [15:0] value);
        drain();
        repeat (60) @(posedge clk);
        device_count_we    <= 1'b1;
        device_count_wdata <= value;
        @(posedge clk);
        device_count_we    <= 1'b0;
    endtask

    // A short program placed at the current PC and then run: instructions mixed
    // with small and full-range data words for next-word operands.
    task automatic run_program();
        logic [15:0] base;
        logic [15:0] w;
        int          count;
        drain();
        base  = last_pc;
        count = $urandom_range(1, 3);
        for (int i = 0; i < 3 * count; i++)
        begin
            case ($urandom_range(3))
                0:       w = 16'($urandom_range(15));
                1:       w = 16'($urandom);
                default: w = random_insn();
            endcase
            send_item(ACT_LOAD, base + 16'(i), w);
        end
        for (int i = 0; i < count; i++)
            send_item(ACT_EXEC, 16'($urandom), 16'($urandom));
    endtask

    task automatic directed_items();
        logic [15:0] prog [13];
        prog = '{encode(OP_SET, 5'h00, OC_NW_LIT), 16'hffff,     // A = 0xffff
                 encode(OP_ADD, 5'h00, 6'h22),                    // A + 1 wraps, EX = 1
                 encode(OP_SET, 5'(OC_PUSHPOP), 6'h1d),           // push EX
                 encode(OP_IFE, 5'h00, 6'h26),                    // false: skip begins
                 encode(OP_IFN, 5'h00, 6'h00),                    // skipped, chain goes on
                 encode(OP_ADD, 5'h00, 6'h22),                    // skipped, chain ends
                 encode(OP_SPECIAL, SP_HWN, 6'h02),               // C = device count
                 encode(OP_SPECIAL, SP_HWQ, 6'h21),
                 encode(OP_SPECIAL, SP_INT, OC_NW_LIT), 16'h1234,
                 encode(5'h18, 5'h00, OC_PUSHPOP),                // unassigned opcode, pops
                 encode(OP_SPECIAL, SP_BRK, 6'h00)};
        foreach (prog[i])
            send_item(ACT_LOAD, 16'(i), prog[i]);
        repeat (11)
            send_item(ACT_EXEC, 16'h0000, 16'h0000);
        send_item(ACT_LOAD, 16'hffff, 16'hffff);
        send_item(ACT_READ, 16'hffff, 16'h0000);
        send_item(ACT_NONE, 16'h5a5a, 16'ha5a5);
    endtask

    initial
    begin
        int phase_start;
        rst_n              = 1'b0;
        request_ch.valid   = 1'b0;
        request_ch.action  = ACT_LOAD;
        request_ch.address = '0;
        request_ch.data    = '0;
        result_ch.ready    = 1'b0;
        device_count_we    = 1'b0;
        device_count_wdata = '0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        items_sent         = 0;
        results_seen       = 0;
        cycle_count        = 0;
        last_pc            = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       write_device_count(16'hffff);
                1:       write_device_count(16'h0000);
                2:       write_device_count(16'($urandom));
                default: write_device_count(16'h0001);
            endcase
            // no idling, idle sender, stalling receiver, then both
            send_idle_pct = (phase == 1) ? 85 : (phase == 3) ? 37 : 0;
            stall_pct     = (phase == 2) ? 85 : (phase == 3) ? 37 : 0;
            phase_start   = items_sent;
            if (phase == 0)
                directed_items();
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(3) == 0)
                    send_item(action_t'($urandom_range(3)), 16'($urandom), 16'($urandom));
                else
                    run_program();
            end
        end

        drain();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
